// ----- src/bwss_pkg.sv -----
// shared types and constants of the battery wake sequencer supervisor
package bwss_pkg;

  localparam int IdW     = 29;
  localparam int DataW   = 64;
  localparam int MsW     = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [MsW-1:0] SettleReset    = 16'd500;
  localparam logic [MsW-1:0] WakeReset      = 16'd1000;
  localparam logic [MsW-1:0] HeartbeatReset = 16'd100;
  localparam logic [MsW-1:0] CapReset       = 16'd300;

  localparam int StandbyBit     = 1;
  localparam int OperationalBit = 3;
  localparam int ErrorBit       = 6;

  localparam logic [7:0] ValLow  = 8'hAA;
  localparam logic [7:0] ValHigh = 8'h55;

  // ceil(2^37 / 100): x / 100 == (x * DivRecip) >> DivShift for any 32-bit x
  localparam logic [31:0] DivRecip = 32'h51EB_851F;
  localparam int          DivShift = 37;

  localparam logic [1:0] BmsStandby = 2'd0;
  localparam logic [1:0] BmsActive  = 2'd1;
  localparam logic [1:0] BmsFault   = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STATUS_ID    = 3'd0,
    REG_ELECTRICS_ID = 3'd1,
    REG_LIMITS_ID    = 3'd2,
    REG_SETTLE       = 3'd3,
    REG_WAKE         = 3'd4,
    REG_HEARTBEAT    = 3'd5,
    REG_CAP          = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [MsW-1:0] settle_delay_ms;
    logic [MsW-1:0] wake_delay_ms;
    logic [MsW-1:0] heartbeat_interval_ms;
    logic [MsW-1:0] port_current_cap_da;
  } back_cfg_t;

  typedef struct packed {
    logic             is_tick;
    logic             hit_status;
    logic             hit_electrics;
    logic             hit_limits;
    logic [DataW-1:0] frame_data;
  } queue_item_t;

  typedef struct packed {
    logic           safe_supply_on;
    logic           main_supply_on;
    logic           wake_on;
    logic [2:0]     sequence_step;
    logic           tx_valid;
    logic [63:0]    tx_data;
    logic [1:0]     bms_status;
    logic [15:0]    charge_limit_da;
    logic [15:0]    discharge_limit_da;
    logic [31:0]    charge_power_w;
    logic [31:0]    discharge_power_w;
  } result_t;

endpackage

// ----- src/bwss_front.sv -----
// front end: configuration registers and classification of incoming items
module bwss_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bwss_pkg::IdW-1:0]     in_frame_id,
  input  logic [bwss_pkg::DataW-1:0]   in_frame_data,
  input  logic                         in_is_tick,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bwss_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bwss_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         q_full,
  output logic                         q_push,
  output bwss_pkg::queue_item_t        q_item,
  output bwss_pkg::back_cfg_t          back_cfg
);
  import bwss_pkg::*;

  logic [IdW-1:0] status_id_r;
  logic [IdW-1:0] electrics_id_r;
  logic [IdW-1:0] limits_id_r;
  back_cfg_t      cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_id_r                 <= '0;
      electrics_id_r              <= '0;
      limits_id_r                 <= '0;
      cfg_r.settle_delay_ms       <= SettleReset;
      cfg_r.wake_delay_ms         <= WakeReset;
      cfg_r.heartbeat_interval_ms <= HeartbeatReset;
      cfg_r.port_current_cap_da   <= CapReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STATUS_ID:    status_id_r    <= cfg_data[IdW-1:0];
        REG_ELECTRICS_ID: electrics_id_r <= cfg_data[IdW-1:0];
        REG_LIMITS_ID:    limits_id_r    <= cfg_data[IdW-1:0];
        REG_SETTLE:       cfg_r.settle_delay_ms       <= cfg_data[MsW-1:0];
        REG_WAKE:         cfg_r.wake_delay_ms         <= cfg_data[MsW-1:0];
        REG_HEARTBEAT:    cfg_r.heartbeat_interval_ms <= cfg_data[MsW-1:0];
        REG_CAP:          cfg_r.port_current_cap_da   <= cfg_data[MsW-1:0];
        default: ;
      endcase
    end
  end

  assign back_cfg  = cfg_r;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_item.is_tick       = in_is_tick;
    q_item.hit_status    = !in_is_tick && (in_frame_id == status_id_r);
    q_item.hit_electrics = !in_is_tick && (in_frame_id == electrics_id_r);
    q_item.hit_limits    = !in_is_tick && (in_frame_id == limits_id_r);
    q_item.frame_data    = in_frame_data;
  end

endmodule

// ----- src/bwss_fifo.sv -----
// short item queue between front end and back end
module bwss_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bwss_pkg::queue_item_t push_item,
  input  logic                  pop,
  output bwss_pkg::queue_item_t head_item,
  output logic                  empty,
  output logic                  full
);
  import bwss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  queue_item_t       slot_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r;
  logic [AW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));
  assign head_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/bwss_back.sv -----
// back end: sequencer, heartbeat, status tracking and limit/power pipeline
module bwss_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bwss_pkg::back_cfg_t   back_cfg,
  input  bwss_pkg::queue_item_t head_item,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output bwss_pkg::result_t     res
);
  import bwss_pkg::*;

  typedef enum logic [2:0] {
    STEP_INIT    = 3'd0,
    STEP_SAFE    = 3'd1,
    STEP_MAIN    = 3'd2,
    STEP_REQUEST = 3'd3,
    STEP_RUNNING = 3'd4
  } step_t;

  // sequencer and supervisor state
  step_t       step_r, step_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] entry_r, entry_nxt;
  logic [31:0] last_tx_r, last_tx_nxt;
  logic [7:0]  alive_r, alive_nxt;
  logic        seen_r, seen_nxt;
  logic        standby_r, standby_nxt;
  logic        oper_r, oper_nxt;
  logic        err_r, err_nxt;
  logic [15:0] volt_r, volt_nxt;
  logic [15:0] chg_raw_r, chg_raw_nxt;
  logic [15:0] dis_raw_r, dis_raw_nxt;

  logic [31:0] held;
  logic [31:0] since_tx;
  logic        tx;
  logic [63:0] txd;
  logic [1:0]  bms;
  logic [15:0] chg;
  logic [15:0] dis;
  logic [14:0] volt_pos;
  logic        gate;
  logic        adv;

  // stage a: state outcome
  logic        a_valid_r;
  logic [2:0]  a_step_r;
  logic        a_tx_r;
  logic [63:0] a_txd_r;
  logic [1:0]  a_bms_r;
  logic [15:0] a_chg_r;
  logic [15:0] a_dis_r;
  logic [14:0] a_volt_r;

  // stage b: limit times voltage
  logic        b_valid_r;
  logic [2:0]  b_step_r;
  logic        b_tx_r;
  logic [63:0] b_txd_r;
  logic [1:0]  b_bms_r;
  logic [15:0] b_chg_r;
  logic [15:0] b_dis_r;
  logic [30:0] b_pc_r;
  logic [30:0] b_pd_r;

  // stage c: output register
  logic        c_valid_r;
  result_t     c_res_r;

  logic [63:0] pc_scaled;
  logic [63:0] pd_scaled;

  assign adv   = !c_valid_r || res_ready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    step_nxt    = step_r;
    now_nxt     = now_r;
    entry_nxt   = entry_r;
    last_tx_nxt = last_tx_r;
    alive_nxt   = alive_r;
    seen_nxt    = seen_r;
    standby_nxt = standby_r;
    oper_nxt    = oper_r;
    err_nxt     = err_r;
    volt_nxt    = volt_r;
    chg_raw_nxt = chg_raw_r;
    dis_raw_nxt = dis_raw_r;
    tx          = 1'b0;
    txd         = '0;
    held        = '0;
    since_tx    = '0;

    if (!head_item.is_tick) begin
      if (head_item.hit_status) begin
        standby_nxt = head_item.frame_data[StandbyBit];
        oper_nxt    = head_item.frame_data[OperationalBit];
        err_nxt     = head_item.frame_data[ErrorBit];
        seen_nxt    = 1'b1;
      end
      if (head_item.hit_electrics) begin
        volt_nxt = head_item.frame_data[31:16];
      end
      if (head_item.hit_limits) begin
        chg_raw_nxt = head_item.frame_data[47:32];
        dis_raw_nxt = head_item.frame_data[63:48];
      end
    end else begin
      now_nxt = now_r + 32'd1;
      held    = now_nxt - entry_r;
      unique case (step_r)
        STEP_INIT: begin
          entry_nxt = now_nxt;
          step_nxt  = STEP_SAFE;
        end
        STEP_SAFE: begin
          if (held >= {16'd0, back_cfg.settle_delay_ms}) begin
            entry_nxt = now_nxt;
            step_nxt  = STEP_MAIN;
          end
        end
        STEP_MAIN: begin
          if (held >= {16'd0, back_cfg.wake_delay_ms}) begin
            entry_nxt = now_nxt;
            step_nxt  = STEP_REQUEST;
          end
        end
        STEP_REQUEST: begin
          if (seen_r && standby_r) begin
            step_nxt = STEP_RUNNING;
          end
        end
        default: ;
      endcase
      since_tx = now_nxt - last_tx_r;
      if (since_tx >= {16'd0, back_cfg.heartbeat_interval_ms}) begin
        tx          = 1'b1;
        last_tx_nxt = now_nxt;
        alive_nxt   = alive_r + 8'd1;
        txd = {ValHigh, ValLow, 24'd0, alive_r, 8'd0, 7'd0,
               (step_nxt == STEP_RUNNING) && !err_r};
      end
    end

    gate     = seen_nxt && (step_nxt == STEP_RUNNING) && !err_nxt && oper_nxt;
    bms      = !seen_nxt ? BmsStandby :
               (err_nxt ? BmsFault : (oper_nxt ? BmsActive : BmsStandby));
    chg      = !gate ? 16'd0 :
               ((chg_raw_nxt < back_cfg.port_current_cap_da) ? chg_raw_nxt
                                                             : back_cfg.port_current_cap_da);
    dis      = !gate ? 16'd0 :
               ((dis_raw_nxt < back_cfg.port_current_cap_da) ? dis_raw_nxt
                                                             : back_cfg.port_current_cap_da);
    volt_pos = volt_nxt[15] ? 15'd0 : volt_nxt[14:0];
  end

  assign pc_scaled = {33'd0, b_pc_r} * {32'd0, DivRecip};
  assign pd_scaled = {33'd0, b_pd_r} * {32'd0, DivRecip};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_INIT;
      now_r     <= '0;
      entry_r   <= '0;
      last_tx_r <= '0;
      alive_r   <= '0;
      seen_r    <= 1'b0;
      standby_r <= 1'b0;
      oper_r    <= 1'b0;
      err_r     <= 1'b0;
      volt_r    <= '0;
      chg_raw_r <= '0;
      dis_raw_r <= '0;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        step_r    <= step_nxt;
        now_r     <= now_nxt;
        entry_r   <= entry_nxt;
        last_tx_r <= last_tx_nxt;
        alive_r   <= alive_nxt;
        seen_r    <= seen_nxt;
        standby_r <= standby_nxt;
        oper_r    <= oper_nxt;
        err_r     <= err_nxt;
        volt_r    <= volt_nxt;
        chg_raw_r <= chg_raw_nxt;
        dis_raw_r <= dis_raw_nxt;
      end
      if (adv) begin
        a_valid_r <= q_pop;
        b_valid_r <= a_valid_r;
        c_valid_r <= b_valid_r;
      end
    end

    if (adv) begin
      a_step_r <= step_nxt;
      a_tx_r   <= tx;
      a_txd_r  <= txd;
      a_bms_r  <= bms;
      a_chg_r  <= chg;
      a_dis_r  <= dis;
      a_volt_r <= volt_pos;

      b_step_r <= a_step_r;
      b_tx_r   <= a_tx_r;
      b_txd_r  <= a_txd_r;
      b_bms_r  <= a_bms_r;
      b_chg_r  <= a_chg_r;
      b_dis_r  <= a_dis_r;
      b_pc_r   <= {15'd0, a_chg_r} * {16'd0, a_volt_r};
      b_pd_r   <= {15'd0, a_dis_r} * {16'd0, a_volt_r};

      c_res_r.safe_supply_on     <= (b_step_r >= STEP_SAFE);
      c_res_r.main_supply_on     <= (b_step_r >= STEP_MAIN);
      c_res_r.wake_on            <= (b_step_r >= STEP_REQUEST);
      c_res_r.sequence_step      <= b_step_r;
      c_res_r.tx_valid           <= b_tx_r;
      c_res_r.tx_data            <= b_txd_r;
      c_res_r.bms_status         <= b_bms_r;
      c_res_r.charge_limit_da    <= b_chg_r;
      c_res_r.discharge_limit_da <= b_dis_r;
      c_res_r.charge_power_w     <= {5'd0, pc_scaled[63:DivShift]};
      c_res_r.discharge_power_w  <= {5'd0, pd_scaled[63:DivShift]};
    end
  end

  assign res_valid = c_valid_r;
  assign res       = c_res_r;

endmodule

// ----- src/battery_wake_sequencer_supervisor.sv -----
// top level of the battery wake sequencer supervisor
//
//   channel  | direction | handshake            | contents
//   in_      | slave     | in_tvalid/in_tready  | tick or received frame
//   out_     | master    | out_tvalid/out_tready| pins, status, frame, limits
//   cfg_     | slave     | cfg_valid/cfg_ready  | register index and value
//
// one item per cycle sustained unless the output stalls; each accepted item passes
// queue, state update, multiply, scale by 1/100 into the output register
// synchronous active-low reset, no clearing pass; cfg_ready is always high
// a stalled output holds the pipeline; the queue keeps in_tready high
// until it fills
module battery_wake_sequencer_supervisor #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [95:0]                    in_tdata,   // frame_id, frame_data, zero pad
  input  logic                           in_tuser,   // opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [175:0]                   out_tdata,  // safe_supply_on, main_supply_on,
                                                     // wake_on, sequence_step, tx_valid,
                                                     // tx_data, bms_status,
                                                     // charge_limit_da,
                                                     // discharge_limit_da,
                                                     // charge_power_w,
                                                     // discharge_power_w, zero pad
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bwss_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bwss_pkg::CfgDataW-1:0]  cfg_data
);
  import bwss_pkg::*;

  queue_item_t push_item;
  queue_item_t head_item;
  back_cfg_t   back_cfg;
  result_t     res;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  logic        q_full;

  bwss_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_frame_id   (in_tdata[IdW-1:0]),
    .in_frame_data (in_tdata[IdW+DataW-1:IdW]),
    .in_is_tick    (in_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item),
    .back_cfg      (back_cfg)
  );

  bwss_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  bwss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .back_cfg  (back_cfg),
    .head_item (head_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {7'd0,
                      res.discharge_power_w,
                      res.charge_power_w,
                      res.discharge_limit_da,
                      res.charge_limit_da,
                      res.bms_status,
                      res.tx_data,
                      res.tx_valid,
                      res.sequence_step,
                      res.wake_on,
                      res.main_supply_on,
                      res.safe_supply_on};

  a_tx_data_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.tx_valid |-> res.tx_data == '0)
    else $error("tx_data set without tx_valid");

  a_pin_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!res.wake_on || res.main_supply_on) &&
                   (!res.main_supply_on || res.safe_supply_on))
    else $error("supply pins out of sequence");

  a_power_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.charge_limit_da == '0 |-> res.charge_power_w == '0)
    else $error("charge power without charge limit");

  a_limits_need_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.charge_limit_da != '0 || res.discharge_limit_da != '0) |->
      res.wake_on && res.bms_status == BmsActive)
    else $error("limits reported outside running step");

endmodule
